[hw/rtl/pdj_pkg.sv]
// Shared types and constants for the periodic deadline job dispatcher.
`default_nettype none
package pdj_pkg;

  localparam int unsigned MaxJobsDef        = 16;
  localparam int unsigned PriorityLevelsDef = 5;
  localparam int unsigned CriticalLevelDef  = 0;

  localparam logic [15:0] MarginReset   = 16'd10;
  localparam logic [7:0]  MaxMissReset  = 8'd3;

  localparam logic [1:0] ActRegister = 2'd0;
  localparam logic [1:0] ActEnable   = 2'd1;
  localparam logic [1:0] ActPass     = 2'd2;
  localparam logic [1:0] ActUnused   = 2'd3;

  localparam logic [1:0] KindAck      = 2'd0;
  localparam logic [1:0] KindDispatch = 2'd1;
  localparam logic [1:0] KindSummary  = 2'd2;

  localparam logic [1:0] StatOk       = 2'd0;
  localparam logic [1:0] StatBadParam = 2'd1;
  localparam logic [1:0] StatNoSlot   = 2'd2;

  localparam logic CfgMargin  = 1'b0;
  localparam logic CfgMaxMiss = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CHECK,
    ST_SUM
  } state_e;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] now_ms;
    logic [31:0] check_ms;
    logic [3:0]  job_slot;
    logic [31:0] period_ticks;
    logic [2:0]  priority_req;
    logic        enable;
  } in_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  status;
    logic [3:0]  job_index;
    logic        violation;
    logic        safe_state_fault;
    logic [15:0] consecutive_misses;
    logic [31:0] total_misses;
    logic [31:0] executions;
    logic        last;
  } out_t;

  // one job record held by a cell
  typedef struct packed {
    logic [31:0] period;
    logic [31:0] deadline;
    logic [2:0]  prio;
    logic        en;
  } rec_t;

  // write command broadcast to all cells while idle
  typedef struct packed {
    logic        reg_wr;
    logic        en_wr;
    logic        en_val;
    rec_t        rec;
  } cell_wr_t;

endpackage
`default_nettype wire

[hw/rtl/periodic_deadline_job_dispatcher.sv]
// Top level: periodic job table on a rotating ring of job cells.
// Usage:
//   Input channel in_valid_i/in_stall_o/in_data_i carries one item (register,
//   enable or pass). Output channel out_valid_o/out_stall_i/out_data_o returns
//   results; last marks the final result of an item.
//   Register and enable items give one ack, loaded the cycle after the
//   transaction; the block is ready again as soon as the output register can
//   take a result.
//   A pass rotates the job ring once per priority level and once more for the
//   critical lateness check, then emits the summary; a receiver stall holds up
//   the pass. One item is worked on at a time.
//   A stall holds the ring in place when a dispatch is waiting; no result is
//   dropped.
//   Configuration writes (cfg_valid_i, ready while idle) set the lateness
//   margin and the consecutive miss limit.
//   Reset clears job count, miss counters and dispatch count and restores the
//   register defaults; job records are undefined until registered.
`default_nettype none
module periodic_deadline_job_dispatcher #(
  parameter int unsigned MAX_JOBS        = pdj_pkg::MaxJobsDef,
  parameter int unsigned PRIORITY_LEVELS = pdj_pkg::PriorityLevelsDef,
  parameter int unsigned CRITICAL_LEVEL  = pdj_pkg::CriticalLevelDef
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output      logic          in_stall_o,
  input  wire pdj_pkg::in_t  in_data_i,
  output      logic          out_valid_o,
  input  wire logic          out_stall_i,
  output      pdj_pkg::out_t out_data_o,
  input  wire logic          cfg_valid_i,
  output      logic          cfg_ready_o,
  input  wire logic          cfg_index_i,
  input  wire logic [15:0]   cfg_data_i
);

  localparam int unsigned IdxW = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int unsigned UW   = $clog2(MAX_JOBS + 1);

  pdj_pkg::state_e state_q, state_d;
  logic [UW-1:0]   used_q, used_d;
  logic [15:0]     streak_q, streak_d;
  logic [31:0]     mtotal_q, mtotal_d;
  logic [31:0]     disp_q, disp_d;
  logic [15:0]     margin_q;
  logic [7:0]      maxmiss_q;
  logic [IdxW-1:0] cnt_q, cnt_d;
  logic [2:0]      lvl_q, lvl_d;
  logic            viol_q, viol_d;
  logic [31:0]     now_q, now_d, chk_q, chk_d;
  logic            ov_q, ov_d;
  pdj_pkg::out_t   od_q, od_d;

  pdj_pkg::rec_t    rec [MAX_JOBS];
  pdj_pkg::rec_t    head_mod;
  pdj_pkg::cell_wr_t wr;
  logic [IdxW-1:0]  wr_slot;
  logic             shift;
  logic             can_load, in_acc, slot_ok, hit, late, lim_fault;
  logic [31:0]      dd, slot32;
  logic [7:0]       lim;
  logic [15:0]      streak_n;
  logic [31:0]      mtotal_n;

  assign can_load   = !ov_q || !out_stall_i;
  assign in_stall_o = (state_q != pdj_pkg::ST_IDLE) || !can_load;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign cfg_ready_o = (state_q == pdj_pkg::ST_IDLE);

  assign slot_ok = ({{(32-UW){1'b0}}, used_q} > 32'(cnt_q));
  assign dd      = chk_q - rec[0].deadline;
  assign late    = slot_ok && rec[0].en && (rec[0].prio == 3'(CRITICAL_LEVEL)) &&
                   !dd[31] && (dd > {16'd0, margin_q});
  assign hit     = slot_ok && rec[0].en && (rec[0].prio == lvl_q) &&
                   !(now_q - rec[0].deadline >= 32'h8000_0000);
  assign slot32  = {28'd0, in_data_i.job_slot};

  always_comb begin
    head_mod = rec[0];
    if (hit && state_q == pdj_pkg::ST_SCAN) begin
      head_mod.deadline = rec[0].deadline + rec[0].period;
    end
  end

  for (genvar k = 0; k < MAX_JOBS; k++) begin : g_cell
    pdj_cell #(.IdxW(IdxW), .Index(k)) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .shift_i   (shift),
      .nb_i      ((k == MAX_JOBS - 1) ? head_mod : rec[(k + 1) % MAX_JOBS]),
      .wr_i      (wr),
      .wr_slot_i (wr_slot),
      .rec_o     (rec[k])
    );
  end

  always_comb begin
    lim       = (maxmiss_q == 8'd0) ? 8'd1 : maxmiss_q;
    streak_n  = (streak_q == 16'hFFFF) ? streak_q : streak_q + 16'd1;
    mtotal_n  = mtotal_q + 32'd1;
    if (!viol_q) begin
      streak_n = 16'd0;
      mtotal_n = mtotal_q;
    end
    lim_fault = (streak_q >= {8'd0, lim});
  end

  always_comb begin
    state_d  = state_q;
    used_d   = used_q;
    streak_d = streak_q;
    mtotal_d = mtotal_q;
    disp_d   = disp_q;
    cnt_d    = cnt_q;
    lvl_d    = lvl_q;
    viol_d   = viol_q;
    now_d    = now_q;
    chk_d    = chk_q;
    ov_d     = ov_q && out_stall_i;
    od_d     = od_q;
    shift    = 1'b0;
    wr       = '0;
    wr.rec.period   = in_data_i.period_ticks;
    wr.rec.deadline = in_data_i.now_ms + in_data_i.period_ticks;
    wr.rec.prio     = in_data_i.priority_req;
    wr.rec.en       = 1'b1;
    wr.en_val       = in_data_i.enable;
    wr_slot         = used_q[IdxW-1:0];

    od_d.kind               = pdj_pkg::KindAck;
    od_d.status             = pdj_pkg::StatOk;
    od_d.job_index          = 4'd0;
    od_d.violation          = 1'b0;
    od_d.safe_state_fault   = lim_fault;
    od_d.consecutive_misses = streak_q;
    od_d.total_misses       = mtotal_q;
    od_d.executions         = disp_q;
    od_d.last               = 1'b1;
    if (!can_load) begin
      od_d = od_q;
    end

    case (state_q)
      pdj_pkg::ST_IDLE: begin
        if (in_acc) begin
          ov_d = 1'b1;
          case (in_data_i.action)
            pdj_pkg::ActRegister: begin
              if (in_data_i.period_ticks != 32'd0 && used_q < UW'(MAX_JOBS)) begin
                wr.reg_wr      = 1'b1;
                used_d         = used_q + UW'(1);
                od_d.job_index = 4'(used_q);
              end else begin
                od_d.status = pdj_pkg::StatBadParam;
              end
            end
            pdj_pkg::ActEnable: begin
              od_d.job_index = in_data_i.job_slot;
              if (slot32 < 32'(used_q)) begin
                wr.en_wr = 1'b1;
                wr_slot  = slot32[IdxW-1:0];
              end else begin
                od_d.status = pdj_pkg::StatNoSlot;
              end
            end
            pdj_pkg::ActPass: begin
              ov_d    = 1'b0;
              state_d = pdj_pkg::ST_SCAN;
              now_d   = in_data_i.now_ms;
              chk_d   = in_data_i.check_ms;
              cnt_d   = '0;
              lvl_d   = 3'd0;
              viol_d  = 1'b0;
            end
            default: begin
              od_d.status = pdj_pkg::StatBadParam;
            end
          endcase
        end
      end
      pdj_pkg::ST_SCAN: begin
        if (!hit || can_load) begin
          shift = 1'b1;
          cnt_d = cnt_q + IdxW'(1);
          if (hit) begin
            disp_d         = disp_q + 32'd1;
            ov_d           = 1'b1;
            od_d.kind      = pdj_pkg::KindDispatch;
            od_d.job_index = 4'(cnt_q);
            od_d.executions = disp_q + 32'd1;
            od_d.last      = 1'b0;
          end
          if (cnt_q == IdxW'(MAX_JOBS - 1)) begin
            cnt_d = '0;
            if (lvl_q == 3'(PRIORITY_LEVELS - 1)) begin
              state_d = pdj_pkg::ST_CHECK;
            end else begin
              lvl_d = lvl_q + 3'd1;
            end
          end
        end
      end
      pdj_pkg::ST_CHECK: begin
        shift  = 1'b1;
        viol_d = viol_q || late;
        cnt_d  = cnt_q + IdxW'(1);
        if (cnt_q == IdxW'(MAX_JOBS - 1)) begin
          cnt_d   = '0;
          state_d = pdj_pkg::ST_SUM;
        end
      end
      pdj_pkg::ST_SUM: begin
        if (can_load) begin
          streak_d                = streak_n;
          mtotal_d                = mtotal_n;
          ov_d                    = 1'b1;
          od_d.kind               = pdj_pkg::KindSummary;
          od_d.violation          = viol_q;
          od_d.consecutive_misses = streak_n;
          od_d.total_misses       = mtotal_n;
          od_d.safe_state_fault   = (streak_n >= {8'd0, lim});
          state_d                 = pdj_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = pdj_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= pdj_pkg::ST_IDLE;
      used_q    <= '0;
      streak_q  <= '0;
      mtotal_q  <= '0;
      disp_q    <= '0;
      ov_q      <= 1'b0;
      cnt_q     <= '0;
      lvl_q     <= '0;
      margin_q  <= pdj_pkg::MarginReset;
      maxmiss_q <= pdj_pkg::MaxMissReset;
    end else begin
      state_q  <= state_d;
      used_q   <= used_d;
      streak_q <= streak_d;
      mtotal_q <= mtotal_d;
      disp_q   <= disp_d;
      ov_q     <= ov_d;
      cnt_q    <= cnt_d;
      lvl_q    <= lvl_d;
      if (cfg_valid_i && cfg_ready_o && cfg_index_i == pdj_pkg::CfgMargin) begin
        margin_q <= cfg_data_i;
      end
      if (cfg_valid_i && cfg_ready_o && cfg_index_i == pdj_pkg::CfgMaxMiss) begin
        maxmiss_q <= cfg_data_i[7:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    viol_q <= viol_d;
    now_q  <= now_d;
    chk_q  <= chk_d;
    od_q   <= od_d;
  end

  assign out_valid_o = ov_q;
  assign out_data_o  = od_q;

`ifndef SYNTHESIS
  a_busy_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != pdj_pkg::ST_IDLE) |-> in_stall_o)
    else $error("input taken while a pass runs");
  a_sum_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pdj_pkg::ST_SUM && can_load) |=> (out_valid_o && out_data_o.last))
    else $error("summary not flagged last");
  a_scan_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pdj_pkg::ST_SCAN && hit && can_load) |=>
      (out_valid_o && !out_data_o.last))
    else $error("dispatch result flagged last");
  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= UW'(MAX_JOBS))
    else $error("job count beyond table size");
`endif

endmodule
`default_nettype wire

[hw/rtl/pdj_cell.sv]
// One job cell of the rotating job ring.
`default_nettype none
module pdj_cell #(
  parameter int unsigned IdxW = 4,
  parameter int unsigned Index = 0
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              shift_i,
  input  wire pdj_pkg::rec_t     nb_i,
  input  wire pdj_pkg::cell_wr_t wr_i,
  input  wire logic [IdxW-1:0]   wr_slot_i,
  output      pdj_pkg::rec_t     rec_o
);

  pdj_pkg::rec_t rec_q, rec_d;
  logic          hit;

  assign hit = (wr_slot_i == IdxW'(Index));

  always_comb begin
    rec_d = rec_q;
    if (shift_i) begin
      rec_d = nb_i;
    end else if (wr_i.reg_wr && hit) begin
      rec_d = wr_i.rec;
    end else if (wr_i.en_wr && hit) begin
      rec_d.en = wr_i.en_val;
    end
  end

  // job record, meaningful only once registered
  always_ff @(posedge clk_i) begin
    rec_q <= rec_d;
  end

  assign rec_o = rec_q;

`ifndef SYNTHESIS
  a_no_wr_in_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    shift_i |-> !(wr_i.reg_wr || wr_i.en_wr))
    else $error("cell write during rotation");
`endif

endmodule
`default_nettype wire

[bench/tb_top.sv]
// Testbench for the periodic deadline job dispatcher: predictor, driver, monitor, checks.
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NJOBS = pdj_pkg::MaxJobsDef;
  localparam int unsigned NLEVELS = pdj_pkg::PriorityLevelsDef;
  localparam int unsigned CRIT = pdj_pkg::CriticalLevelDef;
  localparam int unsigned WATCHDOG = 20000;
  localparam int unsigned DRAIN = 300;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  pdj_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  pdj_pkg::out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = 1'b0;
  logic [15:0] cfg_data = '0;

  always #5 clk = ~clk;

  periodic_deadline_job_dispatcher dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o(out_data),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  // predictor state
  logic [31:0] job_period [NJOBS];
  logic [31:0] job_deadline [NJOBS];
  logic [2:0]  job_prio [NJOBS];
  logic        job_en [NJOBS];
  int unsigned jobs_count;
  logic [15:0] streak;
  logic [31:0] missed_passes;
  logic [31:0] dispatched;
  logic [15:0] margin;
  logic [7:0]  miss_limit;

  pdj_pkg::out_t expected_results[$];
  pdj_pkg::in_t  pending_items[$];
  int unsigned mismatches = 0;
  int unsigned sent = 0;
  int unsigned idle_cycles = 0;
  bit hold_off = 1'b0;

  function automatic pdj_pkg::out_t make_result(logic [1:0] kind, logic [1:0] status,
                                                logic [3:0] idx, logic viol);
    pdj_pkg::out_t r;
    logic [7:0] lim;
    lim = (miss_limit == 8'd0) ? 8'd1 : miss_limit;
    r.kind = kind;
    r.status = status;
    r.job_index = idx;
    r.violation = viol;
    r.safe_state_fault = (streak >= {8'd0, lim});
    r.consecutive_misses = streak;
    r.total_misses = missed_passes;
    r.executions = dispatched;
    r.last = 1'b0;
    return r;
  endfunction

  task automatic predict_item(input pdj_pkg::in_t it);
    pdj_pkg::out_t res[$];
    pdj_pkg::out_t r;
    logic [31:0] d;
    logic late;
    case (it.action)
      pdj_pkg::ActRegister: begin
        if (it.period_ticks != 0 && jobs_count < NJOBS) begin
          job_period[jobs_count] = it.period_ticks;
          job_deadline[jobs_count] = it.now_ms + it.period_ticks;
          job_prio[jobs_count] = it.priority_req;
          job_en[jobs_count] = 1'b1;
          jobs_count++;
          res.push_back(make_result(pdj_pkg::KindAck, pdj_pkg::StatOk,
                                    4'(jobs_count - 1), 1'b0));
        end else begin
          res.push_back(make_result(pdj_pkg::KindAck, pdj_pkg::StatBadParam, 4'd0, 1'b0));
        end
      end
      pdj_pkg::ActEnable: begin
        if (it.job_slot < jobs_count) begin
          job_en[it.job_slot] = it.enable;
          res.push_back(make_result(pdj_pkg::KindAck, pdj_pkg::StatOk, it.job_slot, 1'b0));
        end else begin
          res.push_back(make_result(pdj_pkg::KindAck, pdj_pkg::StatNoSlot,
                                    it.job_slot, 1'b0));
        end
      end
      pdj_pkg::ActPass: begin
        late = 1'b0;
        for (int unsigned lvl = 0; lvl < NLEVELS; lvl++)
          for (int unsigned j = 0; j < jobs_count; j++)
            if (job_prio[j] == lvl && job_en[j] &&
                ((it.now_ms - job_deadline[j]) < 32'h8000_0000)) begin
              job_deadline[j] += job_period[j];
              dispatched++;
              res.push_back(make_result(pdj_pkg::KindDispatch, pdj_pkg::StatOk,
                                        4'(j), 1'b0));
            end
        for (int unsigned j = 0; j < jobs_count; j++)
          if (job_prio[j] == CRIT && job_en[j]) begin
            d = it.check_ms - job_deadline[j];
            if (!d[31] && d > {16'd0, margin}) late = 1'b1;
          end
        if (late) begin
          missed_passes++;
          if (streak != 16'hFFFF) streak++;
        end else begin
          streak = '0;
        end
        res.push_back(make_result(pdj_pkg::KindSummary, pdj_pkg::StatOk, 4'd0, late));
      end
      default: res.push_back(make_result(pdj_pkg::KindAck, pdj_pkg::StatBadParam,
                                         4'd0, 1'b0));
    endcase
    r = res[$];
    r.last = 1'b1;
    res[$] = r;
    foreach (res[i]) expected_results.push_back(res[i]);
  endtask

  // driver: bursts and gaps
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        predict_item(in_data);
        sent++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          in_data <= pending_items.pop_front();
          in_valid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(12, 1);
            gap_left <= ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 1);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor and receiver stall pattern
  int stall_mode = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %p", out_data);
        end else begin
          pdj_pkg::out_t e;
          e = expected_results.pop_front();
          if (e !== out_data) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %p got %p", e, out_data);
          end
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if ($urandom_range(199, 0) == 0) stall_mode <= $urandom_range(2, 0);
      if (hold_off) out_stall <= 1'b1;
      else case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(3, 0) == 0);
        default: out_stall <= ($urandom_range(1, 0) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (idle_cycles >= WATCHDOG) begin
      $display("periodic_deadline_job_dispatcher test failed");
      $finish;
    end
  end

  task automatic write_reg(input logic idx, input logic [15:0] val);
    @(posedge clk);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == pdj_pkg::CfgMargin) margin = val;
    else miss_limit = val[7:0];
  endtask

  task automatic wait_drain();
    while (pending_items.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  function automatic pdj_pkg::in_t rand_item(int unsigned base, int unsigned spread);
    pdj_pkg::in_t it;
    int unsigned p;
    it = '0;
    p = $urandom_range(99, 0);
    it.action = (p < 20) ? pdj_pkg::ActRegister : (p < 35) ? pdj_pkg::ActEnable :
                (p < 97) ? pdj_pkg::ActPass : pdj_pkg::ActUnused;
    it.now_ms = base + $urandom_range(spread, 0);
    it.check_ms = it.now_ms + $urandom_range(40, 0);
    if ($urandom_range(9, 0) == 0) it.check_ms = $urandom;
    it.job_slot = 4'($urandom_range(15, 0));
    it.period_ticks = ($urandom_range(7, 0) == 0) ? $urandom : $urandom_range(60, 0);
    it.priority_req = 3'($urandom_range(7, 0));
    it.enable = 1'($urandom_range(1, 0));
    return it;
  endfunction

  task automatic add(input logic [1:0] act, input logic [31:0] now_v,
                     input logic [31:0] chk, input logic [3:0] slot,
                     input logic [31:0] per, input logic [2:0] pr, input logic en);
    pdj_pkg::in_t it;
    it.action = act; it.now_ms = now_v; it.check_ms = chk; it.job_slot = slot;
    it.period_ticks = per; it.priority_req = pr; it.enable = en;
    pending_items.push_back(it);
  endtask

  initial begin
    logic [31:0] tick;
    jobs_count = 0; streak = '0; missed_passes = '0; dispatched = '0;
    margin = pdj_pkg::MarginReset; miss_limit = pdj_pkg::MaxMissReset;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: refused and odd items, extremes, wrap
    add(pdj_pkg::ActRegister, 32'd0, 32'd0, 4'd0, 32'd0, 3'd0, 1'b0);
    add(pdj_pkg::ActEnable, 32'd0, 32'd0, 4'd15, 32'd0, 3'd0, 1'b1);
    add(pdj_pkg::ActUnused, '1, '1, '1, '1, '1, 1'b1);
    add(pdj_pkg::ActRegister, 32'hFFFF_FFF0, 32'd0, 4'd0, 32'd16, 3'd0, 1'b0);
    add(pdj_pkg::ActRegister, 32'hFFFF_FFF0, 32'd0, 4'd0, 32'hFFFF_FFFF, 3'd4, 1'b0);
    add(pdj_pkg::ActRegister, 32'd5, 32'd0, 4'd0, 32'd3, 3'd7, 1'b0);
    add(pdj_pkg::ActRegister, 32'd0, 32'd0, 4'd0, 32'h8000_0000, 3'd2, 1'b0);
    add(pdj_pkg::ActPass, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd0, 32'd0, 3'd0, 1'b0);
    add(pdj_pkg::ActPass, 32'd0, 32'd100, 4'd0, 32'd0, 3'd0, 1'b0);
    add(pdj_pkg::ActPass, 32'd20, 32'd40, 4'd0, 32'd0, 3'd0, 1'b0);
    add(pdj_pkg::ActPass, 32'd40, 32'd90, 4'd0, 32'd0, 3'd0, 1'b0);
    add(pdj_pkg::ActPass, 32'd41, 32'd90, 4'd0, 32'd0, 3'd0, 1'b0);
    add(pdj_pkg::ActEnable, 32'd0, 32'd0, 4'd0, 32'd0, 3'd0, 1'b0);
    add(pdj_pkg::ActEnable, 32'd0, 32'd0, 4'd4, 32'd0, 3'd0, 1'b0);
    add(pdj_pkg::ActPass, 32'd80, 32'd200, 4'd0, 32'd0, 3'd0, 1'b0);
    add(pdj_pkg::ActEnable, 32'd0, 32'd0, 4'd0, 32'd0, 3'd0, 1'b1);
    for (int i = 0; i < 14; i++)
      add(pdj_pkg::ActRegister, 32'd100, 32'd0, 4'd0, 32'(i + 1), 3'(i % 6), 1'b0);
    add(pdj_pkg::ActPass, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 4'd0, 32'd0, 3'd0, 1'b0);
    wait_drain();

    write_reg(pdj_pkg::CfgMargin, 16'd0);
    write_reg(pdj_pkg::CfgMaxMiss, 16'd0);
    tick = 32'd200;
    for (int i = 0; i < 80; i++) begin
      pending_items.push_back(rand_item(tick, 5));
      tick += 5;
    end
    // long receiver hold-off while items keep coming
    fork
      begin
        hold_off = 1'b1;
        repeat (400) @(posedge clk);
        hold_off = 1'b0;
      end
    join_none
    wait_drain();

    write_reg(pdj_pkg::CfgMargin, 16'hFFFF);
    write_reg(pdj_pkg::CfgMaxMiss, 16'd255);
    for (int i = 0; i < 80; i++) begin
      pending_items.push_back(rand_item(tick, 20));
      tick += $urandom_range(20, 0);
    end
    wait_drain();

    write_reg(pdj_pkg::CfgMargin, 16'($urandom_range(30, 1)));
    write_reg(pdj_pkg::CfgMaxMiss, 16'd1);
    tick = 32'hFFFF_FE00;
    for (int i = 0; i < 120; i++) begin
      pending_items.push_back(rand_item(tick, 8));
      tick += $urandom_range(8, 0);
    end
    wait_drain();

    if (mismatches == 0 && expected_results.size() == 0)
      $display("periodic_deadline_job_dispatcher test passed");
    else
      $display("periodic_deadline_job_dispatcher test failed");
    $finish;
  end
endmodule
`default_nettype wire
